### src/pfma_pkg.sv
// ----------------------------------------------------------------------------
// pfma_pkg
// Shared types and constants of the modular ALU over the prime 1000000007.
// ----------------------------------------------------------------------------
`default_nettype none

package pfma_pkg;

  localparam int unsigned RES_W    = 30;
  localparam int unsigned OPND_W   = 32;
  localparam int unsigned EXP_BITS = 32;

  localparam logic [RES_W-1:0] PRIME = 30'd1000000007;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_POW = 3'd3,
    KIND_INV = 3'd4,
    KIND_DIV = 3'd5
  } kind_t;

  typedef struct packed {
    logic              valid;
    logic [OPND_W-1:0] x;
    logic [RES_W-1:0]  y;
  } mm_req_t;

  typedef struct packed {
    logic             valid;
    logic [RES_W-1:0] value;
  } mm_rsp_t;

endpackage

`default_nettype wire

### src/prime_field_modular_alu_unit.sv
// ----------------------------------------------------------------------------
// prime_field_modular_alu_unit
// Modular add, subtract, multiply, power, inverse and divide mod 1000000007.
//
//   channel | ports                                   | transfer when
//   --------+-----------------------------------------+---------------------
//   input   | start, busy, in_kind, in_operand_a/_b   | start && !busy
//   result  | out_valid, out_result                   | out_valid (1 cycle)
//
// Each operand is reduced through the shared 4-stage modular multiplier.
// Add/subtract then finish in the adder; multiply takes one more product.
// Power does a multiply per set and a square per exponent bit up to the top
// set bit; inverse raises to PRIME-2, divide multiplies a by that inverse of b.
// The result strobe follows the last busy cycle.
// Reset is synchronous and leaves the unit idle. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_field_modular_alu_unit
  import pfma_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_kind,
  input  wire logic [OPND_W-1:0] in_operand_a,
  input  wire logic [OPND_W-1:0] in_operand_b,
  output logic                   out_valid,
  output logic [RES_W-1:0]       out_result
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RED_A = 9'b000000010,
    S_RED_B = 9'b000000100,
    S_ALU   = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_PSTEP = 9'b000100000,
    S_PMUL  = 9'b001000000,
    S_PSQR  = 9'b010000000,
    S_FMUL  = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  logic              inflight_r, inflight_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]  out_result_r, out_result_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic [OPND_W-1:0] a_raw_r, a_raw_nxt, b_raw_r, b_raw_nxt;
  logic [RES_W-1:0]  ra_r, ra_nxt, rb_r, rb_nxt;
  logic [RES_W-1:0]  acc_r, acc_nxt, sq_r, sq_nxt;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic [RES_W:0]   sum;
  logic [RES_W-1:0] add_res, sub_res;
  logic             mm_state;

  pfma_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  assign sum     = {1'b0, ra_r} + {1'b0, rb_r};
  assign add_res = (sum >= {1'b0, PRIME}) ? RES_W'(sum - {1'b0, PRIME}) : sum[RES_W-1:0];
  assign sub_res = (ra_r >= rb_r) ? ra_r - rb_r : RES_W'({1'b0, ra_r} + {1'b0, PRIME}
                                                        - {1'b0, rb_r});

  always_comb begin
    mm_state = 1'b0;
    mm_req.x = '0;
    mm_req.y = '0;
    unique case (state_r)
      S_RED_A: begin
        mm_state = 1'b1;
        mm_req.x = a_raw_r;
        mm_req.y = RES_W'(1);
      end
      S_RED_B: begin
        mm_state = 1'b1;
        mm_req.x = b_raw_r;
        mm_req.y = RES_W'(1);
      end
      S_MUL: begin
        mm_state = 1'b1;
        mm_req.x = OPND_W'(ra_r);
        mm_req.y = rb_r;
      end
      S_PMUL: begin
        mm_state = 1'b1;
        mm_req.x = OPND_W'(acc_r);
        mm_req.y = sq_r;
      end
      S_PSQR: begin
        mm_state = 1'b1;
        mm_req.x = OPND_W'(sq_r);
        mm_req.y = sq_r;
      end
      S_FMUL: begin
        mm_state = 1'b1;
        mm_req.x = OPND_W'(ra_r);
        mm_req.y = acc_r;
      end
      default: begin
        mm_state = 1'b0;
      end
    endcase
    mm_req.valid = mm_state && !inflight_r;
  end

  always_comb begin
    state_nxt      = state_r;
    inflight_nxt   = inflight_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    kind_nxt       = kind_r;
    a_raw_nxt      = a_raw_r;
    b_raw_nxt      = b_raw_r;
    ra_nxt         = ra_r;
    rb_nxt         = rb_r;
    acc_nxt        = acc_r;
    sq_nxt         = sq_r;
    exp_nxt        = exp_r;

    if (mm_req.valid) begin
      inflight_nxt = 1'b1;
    end else if (mm_rsp.valid) begin
      inflight_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          a_raw_nxt = in_operand_a;
          b_raw_nxt = in_operand_b;
          state_nxt = S_RED_A;
        end
      end
      S_RED_A: begin
        if (mm_rsp.valid) begin
          ra_nxt    = mm_rsp.value;
          state_nxt = S_RED_B;
        end
      end
      S_RED_B: begin
        if (mm_rsp.valid) begin
          rb_nxt  = mm_rsp.value;
          acc_nxt = RES_W'(1);
          case (kind_r) inside
            KIND_ADD, KIND_SUB: begin
              state_nxt = S_ALU;
            end
            KIND_MUL: begin
              state_nxt = S_MUL;
            end
            KIND_POW: begin
              sq_nxt    = ra_r;
              exp_nxt   = EXP_BITS'(b_raw_r);
              state_nxt = S_PSTEP;
            end
            KIND_INV: begin
              sq_nxt    = ra_r;
              exp_nxt   = EXP_BITS'(PRIME - RES_W'(2));
              state_nxt = S_PSTEP;
            end
            KIND_DIV: begin
              sq_nxt    = mm_rsp.value;
              exp_nxt   = EXP_BITS'(PRIME - RES_W'(2));
              state_nxt = S_PSTEP;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_result_nxt = '0;
              state_nxt      = S_IDLE;
            end
          endcase
        end
      end
      S_ALU: begin
        out_valid_nxt  = 1'b1;
        out_result_nxt = (kind_r == KIND_ADD) ? add_res : sub_res;
        state_nxt      = S_IDLE;
      end
      S_MUL: begin
        if (mm_rsp.valid) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = mm_rsp.value;
          state_nxt      = S_IDLE;
        end
      end
      S_PSTEP: begin
        if (exp_r == '0) begin
          if (kind_r == KIND_DIV) begin
            state_nxt = S_FMUL;
          end else begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = acc_r;
            state_nxt      = S_IDLE;
          end
        end else if (exp_r[0]) begin
          state_nxt = S_PMUL;
        end else begin
          state_nxt = S_PSQR;
        end
      end
      S_PMUL: begin
        if (mm_rsp.valid) begin
          acc_nxt   = mm_rsp.value;
          state_nxt = S_PSQR;
        end
      end
      S_PSQR: begin
        if (mm_rsp.valid) begin
          sq_nxt    = mm_rsp.value;
          exp_nxt   = exp_r >> 1;
          state_nxt = S_PSTEP;
        end
      end
      S_FMUL: begin
        if (mm_rsp.valid) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = mm_rsp.value;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inflight_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inflight_r  <= inflight_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
    kind_r       <= kind_nxt;
    a_raw_r      <= a_raw_nxt;
    b_raw_r      <= b_raw_nxt;
    ra_r         <= ra_nxt;
    rb_r         <= rb_nxt;
    acc_r        <= acc_nxt;
    sq_r         <= sq_nxt;
    exp_r        <= exp_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire

### src/pfma_modmul.sv
// ----------------------------------------------------------------------------
// pfma_modmul
// Four-stage Barrett modular multiplier: (x * y) mod PRIME for x * y < 2^60
// and y < PRIME. One request in flight at a time under the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pfma_modmul
  import pfma_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire mm_req_t req,
  output mm_rsp_t      rsp
);

  // floor(2^60 / PRIME), 31 bits
  localparam logic [30:0] MU = 31'((64'd1 << 60) / 64'(PRIME));

  logic        s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [59:0] prod_r;
  logic [31:0] x2_lo_r, x3_lo_r;
  logic [30:0] t_r;
  logic [31:0] qp_r;
  logic [RES_W-1:0] res_r;

  logic [59:0] prod_full;
  logic [61:0] t_full;
  logic [31:0] q_lo;
  logic [31:0] r0, r1, r2;

  assign prod_full = 60'(req.x) * 60'(req.y);
  assign t_full    = 62'(prod_r[59:29]) * 62'(MU);
  assign q_lo      = {1'b0, t_r};

  assign r0 = x3_lo_r - qp_r;
  assign r1 = (r0 >= 32'(PRIME)) ? r0 - 32'(PRIME) : r0;
  assign r2 = (r1 >= 32'(PRIME)) ? r1 - 32'(PRIME) : r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= req.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_full;
    t_r     <= t_full[61:31];
    x2_lo_r <= prod_r[31:0];
    qp_r    <= q_lo * 32'(PRIME);
    x3_lo_r <= x2_lo_r;
    res_r   <= r2[RES_W-1:0];
  end

  assign rsp.valid = s4_v_r;
  assign rsp.value = res_r;

endmodule

`default_nettype wire
